// ===== rtl/csvs_pkg.sv =====
// Shared types, register indexes and character codes for the CSV column statistics core.
package csvs_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int EV_VALUE_BITS  = 64;
    localparam int SUM_BITS       = 64;
    localparam int COUNT_BITS     = 32;
    localparam int OUT_VALUE_BITS = 32;
    localparam int COL_BITS       = 8;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_INDEX    = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SKIP_FIRST_LINE = 8'd1;

    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VTAB    = 8'h0B;
    localparam logic [7:0] CH_FFEED   = 8'h0C;
    localparam logic [7:0] CH_CRET    = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_beat_t;

    typedef struct packed {
        logic signed [OUT_VALUE_BITS-1:0] value_min;
        logic signed [OUT_VALUE_BITS-1:0] value_max;
        logic signed [SUM_BITS-1:0]       value_sum;
        logic [COUNT_BITS-1:0]            value_count;
        logic                             any_valid;
    } out_beat_t;

    // Event from the parser to the accumulator: a finished column value and/or end of stream.
    typedef struct packed {
        logic                            is_end;
        logic                            has_value;
        logic signed [EV_VALUE_BITS-1:0] value;
    } ev_t;

endpackage

// ===== rtl/csvs_parser.sv =====
// Byte-level CSV tokenizer and integer parser that emits column value events.
module csvs_parser #(
    parameter int VALUE_BITS = csvs_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  csvs_pkg::in_beat_t                  s_data,
    input  logic                                cfg_valid,
    input  logic [csvs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [csvs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic                                ev_valid,
    input  logic                                ev_ready,
    output csvs_pkg::ev_t                       ev
);
    import csvs_pkg::*;

    typedef enum logic [2:0] {
        PH_WS, PH_SIGN, PH_DIG, PH_DONE, PH_FAIL
    } phase_t;

    localparam logic [VALUE_BITS-1:0] CAP     = VALUE_BITS'(1) << (VALUE_BITS - 1);
    localparam logic [VALUE_BITS-1:0] POS_MAX = CAP - VALUE_BITS'(1);
    // Largest magnitude that may take one more digit d without passing CAP.
    localparam logic [VALUE_BITS-1:0] THR [10] = '{
        (CAP - VALUE_BITS'(0)) / 10, (CAP - VALUE_BITS'(1)) / 10,
        (CAP - VALUE_BITS'(2)) / 10, (CAP - VALUE_BITS'(3)) / 10,
        (CAP - VALUE_BITS'(4)) / 10, (CAP - VALUE_BITS'(5)) / 10,
        (CAP - VALUE_BITS'(6)) / 10, (CAP - VALUE_BITS'(7)) / 10,
        (CAP - VALUE_BITS'(8)) / 10, (CAP - VALUE_BITS'(9)) / 10
    };

    logic [COL_BITS-1:0]   col_idx_reg,  col_idx_next;
    logic                  skip_reg,     skip_next;
    logic                  hdr_reg,      hdr_next;
    logic                  started_reg,  started_next;
    logic [COL_BITS-1:0]   tok_col_reg,  tok_col_next;
    logic                  in_tok_reg,   in_tok_next;
    logic                  line_fin_reg, line_fin_next;
    phase_t                phase_reg,    phase_next;
    logic                  sq_reg,       sq_next;
    logic                  lwq_reg,      lwq_next;
    logic                  neg_reg,      neg_next;
    logic [VALUE_BITS-1:0] mag_reg,      mag_next;
    logic                  ev_valid_reg, ev_valid_next;
    ev_t                   ev_reg,       ev_next;

    logic                  in_fire;
    logic [7:0]            c;
    logic                  is_target, is_digit, is_space, is_quote, is_delim;
    logic [3:0]            dval;
    logic [VALUE_BITS-1:0] mag_step;
    phase_t                p_phase;
    logic                  p_neg;
    logic [VALUE_BITS-1:0] p_mag;
    logic                  close_ok, close_live;
    logic [COL_BITS-1:0]   close_col;
    logic signed [VALUE_BITS-1:0] close_val;

    assign s_ready  = !ev_valid_reg || ev_ready;
    assign in_fire  = s_valid && s_ready;
    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

    always_comb begin
        c         = s_data.data_byte;
        is_target = tok_col_reg == col_idx_reg;
        is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        is_space  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE) ||
                    (c == CH_VTAB) || (c == CH_FFEED) || (c == CH_CRET);
        is_quote  = c == CH_QUOTE;
        is_delim  = (c == CH_COMMA) || (c == CH_NEWLINE);
        dval      = is_digit ? 4'(c - CH_ZERO) : 4'd0;

        // Saturate at CAP once the next digit would overflow.
        if (mag_reg > THR[dval]) begin
            mag_step = CAP;
        end else begin
            mag_step = (mag_reg << 3) + (mag_reg << 1) + VALUE_BITS'(dval);
        end

        p_phase = phase_reg;
        p_neg   = neg_reg;
        p_mag   = mag_reg;
        case (phase_reg)
            PH_WS: begin
                if (is_space) begin
                    p_phase = PH_WS;
                end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                    p_neg   = c == CH_MINUS;
                    p_phase = PH_SIGN;
                end else if (is_digit) begin
                    p_mag   = mag_step;
                    p_phase = PH_DIG;
                end else begin
                    p_phase = PH_FAIL;
                end
            end
            PH_SIGN: begin
                if (is_digit) begin
                    p_mag   = mag_step;
                    p_phase = PH_DIG;
                end else begin
                    p_phase = PH_FAIL;
                end
            end
            PH_DIG: begin
                if (is_digit) begin
                    p_mag = mag_step;
                end else begin
                    p_phase = PH_DONE;
                end
            end
            default: p_phase = phase_reg;
        endcase

        // Token close: target column yields a value, others advance the column count.
        close_live = in_tok_reg && !line_fin_reg;
        close_ok   = close_live && is_target &&
                     ((phase_reg == PH_DIG) || (phase_reg == PH_DONE)) &&
                     (!sq_reg || lwq_reg);
        close_col  = (close_live && !is_target && (tok_col_reg != {COL_BITS{1'b1}})) ?
                     tok_col_reg + COL_BITS'(1) : tok_col_reg;
        if (neg_reg) begin
            close_val = -$signed(mag_reg);
        end else begin
            close_val = $signed((mag_reg > POS_MAX) ? POS_MAX : mag_reg);
        end

        col_idx_next  = col_idx_reg;
        skip_next     = skip_reg;
        hdr_next      = hdr_reg;
        started_next  = started_reg;
        tok_col_next  = tok_col_reg;
        in_tok_next   = in_tok_reg;
        line_fin_next = line_fin_reg;
        phase_next    = phase_reg;
        sq_next       = sq_reg;
        lwq_next      = lwq_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        ev_next       = ev_reg;
        ev_valid_next = ev_valid_reg && !ev_ready;

        if (in_fire) begin
            ev_next.is_end    = s_data.end_of_input;
            ev_next.has_value = 1'b0;
            ev_next.value     = EV_VALUE_BITS'(close_val);
            ev_valid_next     = s_data.end_of_input;
            if (s_data.end_of_input) begin
                ev_next.has_value = !hdr_reg && close_ok;
                hdr_next      = skip_reg;
                started_next  = 1'b0;
                tok_col_next  = '0;
                line_fin_next = 1'b0;
                in_tok_next   = 1'b0;
                phase_next    = PH_WS;
                sq_next       = 1'b0;
                lwq_next      = 1'b0;
                neg_next      = 1'b0;
                mag_next      = '0;
            end else begin
                started_next = 1'b1;
                if (hdr_reg) begin
                    if (c == CH_NEWLINE) begin
                        hdr_next = 1'b0;
                    end
                end else if (is_delim) begin
                    ev_next.has_value = close_ok;
                    ev_valid_next     = close_ok;
                    tok_col_next      = close_col;
                    // The target token ends the line whether or not it parsed.
                    line_fin_next     = line_fin_reg || (close_live && is_target);
                    in_tok_next       = 1'b0;
                    phase_next        = PH_WS;
                    sq_next           = 1'b0;
                    lwq_next          = 1'b0;
                    neg_next          = 1'b0;
                    mag_next          = '0;
                    if (c == CH_NEWLINE) begin
                        tok_col_next  = '0;
                        line_fin_next = 1'b0;
                    end
                end else if (!line_fin_reg) begin
                    in_tok_next = 1'b1;
                    if (is_target) begin
                        lwq_next = is_quote;
                        if (!in_tok_reg && is_quote) begin
                            sq_next = 1'b1;
                        end else begin
                            phase_next = p_phase;
                            neg_next   = p_neg;
                            mag_next   = p_mag;
                        end
                    end
                end
            end
        end

        // Writes must arrive only while idle; the block itself does not enforce this.
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_COLUMN_INDEX: col_idx_next = cfg_data;
                REG_SKIP_FIRST_LINE: begin
                    skip_next = cfg_data[0];
                    if (!started_reg) begin
                        hdr_next = cfg_data[0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_idx_reg  <= '0;
            skip_reg     <= 1'b0;
            hdr_reg      <= 1'b0;
            started_reg  <= 1'b0;
            tok_col_reg  <= '0;
            in_tok_reg   <= 1'b0;
            line_fin_reg <= 1'b0;
            phase_reg    <= PH_WS;
            sq_reg       <= 1'b0;
            lwq_reg      <= 1'b0;
            neg_reg      <= 1'b0;
            mag_reg      <= '0;
            ev_valid_reg <= 1'b0;
        end else begin
            col_idx_reg  <= col_idx_next;
            skip_reg     <= skip_next;
            hdr_reg      <= hdr_next;
            started_reg  <= started_next;
            tok_col_reg  <= tok_col_next;
            in_tok_reg   <= in_tok_next;
            line_fin_reg <= line_fin_next;
            phase_reg    <= phase_next;
            sq_reg       <= sq_next;
            lwq_reg      <= lwq_next;
            neg_reg      <= neg_next;
            mag_reg      <= mag_next;
            ev_valid_reg <= ev_valid_next;
        end
        ev_reg <= ev_next;
    end

endmodule

// ===== rtl/csvs_accum.sv =====
// Running min, max, saturating sum and count, with the result output register.
module csvs_accum #(
    parameter int VALUE_BITS = csvs_pkg::VALUE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ev_valid,
    output logic                ev_ready,
    input  csvs_pkg::ev_t       ev,
    output logic                m_valid,
    input  logic                m_ready,
    output csvs_pkg::out_beat_t m_data
);
    import csvs_pkg::*;

    localparam logic signed [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic signed [VALUE_BITS-1:0] min_reg, min_next;
    logic signed [VALUE_BITS-1:0] max_reg, max_next;
    logic signed [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [COUNT_BITS-1:0]        cnt_reg, cnt_next;
    logic                         m_valid_reg, m_valid_next;
    out_beat_t                    m_data_reg, m_data_next;

    logic                         ev_fire;
    logic signed [VALUE_BITS-1:0] v;
    logic signed [SUM_BITS:0]     sum_wide;
    logic signed [SUM_BITS-1:0]   min_ext, max_ext;
    logic                         any;

    assign ev_ready = !ev.is_end || !m_valid_reg || m_ready;
    assign ev_fire  = ev_valid && ev_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        v        = ev.value[VALUE_BITS-1:0];
        sum_wide = {sum_reg[SUM_BITS-1], sum_reg} + {ev.value[EV_VALUE_BITS-1], ev.value};

        min_next = min_reg;
        max_next = max_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (ev_fire && ev.has_value) begin
            if (v < min_reg) begin
                min_next = v;
            end
            if (v > max_reg) begin
                max_next = v;
            end
            // Clamp on signed overflow.
            if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
                sum_next = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                              : {1'b0, {(SUM_BITS-1){1'b1}}};
            end else begin
                sum_next = sum_wide[SUM_BITS-1:0];
            end
            if (cnt_reg != {COUNT_BITS{1'b1}}) begin
                cnt_next = cnt_reg + COUNT_BITS'(1);
            end
        end

        min_ext = SUM_BITS'(min_next);
        max_ext = SUM_BITS'(max_next);
        any     = cnt_next != '0;

        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (ev_fire && ev.is_end) begin
            m_valid_next            = 1'b1;
            m_data_next.value_min   = any ? min_ext[OUT_VALUE_BITS-1:0] : '0;
            m_data_next.value_max   = any ? max_ext[OUT_VALUE_BITS-1:0] : '0;
            m_data_next.value_sum   = sum_next;
            m_data_next.value_count = cnt_next;
            m_data_next.any_valid   = any;
            min_next = V_MAX;
            max_next = V_MIN;
            sum_next = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg     <= V_MAX;
            max_reg     <= V_MIN;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            min_reg     <= min_next;
            max_reg     <= max_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

endmodule

// ===== rtl/csv_column_integer_stats_core.sv =====
// Top level: CSV column min/max/sum/count over a byte stream, one byte beat per cycle unless the input stalls.
// Pipeline: parser plus event register form stage one, accumulator plus result register
// stage two; an accepted delimiter or end beat passes the event register, then updates the
// running statistics or loads the result beat. An end event that finds the last result still
// untaken holds in the event register and stalls the byte input until that result beat is taken.
// Reset (aresetn low, synchronous) clears control state, sets min/max to their extremes
// and both configuration registers to zero; no clearing pass follows.
module csv_column_integer_stats_core #(
    parameter int VALUE_BITS = csvs_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Byte stream in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  csvs_pkg::in_beat_t                  s_data,
    // Result out
    output logic                                m_valid,
    input  logic                                m_ready,
    output csvs_pkg::out_beat_t                 m_data,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csvs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [csvs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import csvs_pkg::*;

    logic ev_valid;
    logic ev_ready;
    ev_t  ev;

    // Register writes are always accepted: cfg_ready is tied high.
    assign cfg_ready = 1'b1;

    // Tokenize, select the column and parse the integer; emit value/end events.
    csvs_parser #(
        .VALUE_BITS(VALUE_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev        (ev)
    );

    // Fold values into the statistics; hold the result until taken.
    csvs_accum #(
        .VALUE_BITS(VALUE_BITS)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev       (ev),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== dv/tb_csv_column_integer_stats_core.sv =====
// Testbench for the CSV column statistics core: directed and random CSV streams, scoreboarded.
`timescale 1ns / 1ps

module tb_csv_column_integer_stats_core;
    import csvs_pkg::*;

    localparam int RESULT_SETTLE  = 4;     // cycles for an end beat to clear both stages
    localparam int WATCHDOG_LIMIT = 5000;  // cycles without any handshake before giving up
    localparam int RANDOM_BEATS   = 1400;

    // Parser phases of the predictor, following the %d scan of one token.
    typedef enum logic [2:0] {
        PH_LEAD_WS,
        PH_SIGN_SEEN,
        PH_DIGITS,
        PH_TRAILING,
        PH_BAD
    } scan_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_beat_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    csv_column_integer_stats_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Expected results, oldest first, and the text waiting to be sent.
    out_beat_t   stats_exp_q[$];
    logic [7:0]  text_q[$];
    out_beat_t   stats_exp;
    int          mismatches  = 0;
    int          beats_sent  = 0;
    int          idle_cycles = 0;
    bit          no_idle     = 1'b0;

    // ------------------------------------------------------------------
    // Column statistics predictor: configuration, scan and running state
    // ------------------------------------------------------------------
    logic [7:0]  pr_col;
    logic        pr_skip;
    logic        pr_header;
    logic        pr_started;
    logic [7:0]  pr_tcol;
    logic        pr_in_tok;
    logic        pr_line_done;
    scan_phase_t pr_phase;
    logic        pr_open_quote;
    logic        pr_last_quote;
    logic        pr_neg;
    logic [63:0] pr_mag;
    logic        pr_mag_ovf;
    longint      pr_min;
    longint      pr_max;
    longint      pr_sum;
    logic [31:0] pr_count;

    function automatic void scan_clear_token();
        pr_in_tok     = 1'b0;
        pr_phase      = PH_LEAD_WS;
        pr_open_quote = 1'b0;
        pr_last_quote = 1'b0;
        pr_neg        = 1'b0;
        pr_mag        = '0;
        pr_mag_ovf    = 1'b0;
    endfunction

    function automatic void stats_clear_all();
        pr_header    = pr_skip;
        pr_started   = 1'b0;
        pr_tcol      = '0;
        pr_line_done = 1'b0;
        scan_clear_token();
        pr_min   = 64'sd2147483647;
        pr_max   = -64'sd2147483648;
        pr_sum   = 0;
        pr_count = '0;
    endfunction

    function automatic bit is_space_char(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_VTAB ||
               c == CH_FFEED || c == CH_CRET;
    endfunction

    function automatic void scan_add_digit(logic [7:0] c);
        logic [63:0] d;
        logic [63:0] cap;
        d   = 64'(c - CH_ZERO);
        cap = 64'd1 << 31;
        if (pr_mag > (cap - d) / 10) begin
            pr_mag     = cap;
            pr_mag_ovf = 1'b1;
        end else begin
            pr_mag = pr_mag * 10 + d;
        end
    endfunction

    function automatic void scan_char(logic [7:0] c);
        bit digit;
        digit = c >= CH_ZERO && c <= CH_NINE;
        case (pr_phase)
            PH_LEAD_WS: begin
                if (is_space_char(c)) begin
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    pr_neg   = c == CH_MINUS;
                    pr_phase = PH_SIGN_SEEN;
                end else if (digit) begin
                    scan_add_digit(c);
                    pr_phase = PH_DIGITS;
                end else begin
                    pr_phase = PH_BAD;
                end
            end
            PH_SIGN_SEEN: begin
                if (digit) begin
                    scan_add_digit(c);
                    pr_phase = PH_DIGITS;
                end else begin
                    pr_phase = PH_BAD;
                end
            end
            PH_DIGITS: begin
                if (digit) scan_add_digit(c);
                else pr_phase = PH_TRAILING;
            end
            default: ;
        endcase
    endfunction

    // Fold the scanned column value into min, max, sum and count.
    function automatic void stats_take_value();
        longint      v;
        logic [63:0] m;
        logic [63:0] cap;
        bit          ok;
        cap = 64'd1 << 31;
        ok  = (pr_phase == PH_DIGITS || pr_phase == PH_TRAILING) &&
              (!pr_open_quote || pr_last_quote);
        if (ok) begin
            if (pr_neg) begin
                v = (pr_mag == 0) ? 0 : -longint'(pr_mag - 1) - 1;
            end else begin
                m = (pr_mag > cap - 1) ? cap - 1 : pr_mag;
                v = longint'(m);
            end
            if (v < pr_min) pr_min = v;
            if (v > pr_max) pr_max = v;
            if (v > 0 && pr_sum > 64'sh7FFFFFFFFFFFFFFF - v) pr_sum = 64'sh7FFFFFFFFFFFFFFF;
            else if (v < 0 && pr_sum < -64'sh7FFFFFFFFFFFFFFF - 1 - v)
                pr_sum = -64'sh7FFFFFFFFFFFFFFF - 1;
            else pr_sum = pr_sum + v;
            if (pr_count != 32'hFFFFFFFF) pr_count = pr_count + 32'd1;
        end
    endfunction

    function automatic void scan_close_token();
        if (pr_in_tok && !pr_line_done) begin
            if (pr_tcol == pr_col) begin
                stats_take_value();
                pr_line_done = 1'b1;
            end else if (pr_tcol != 8'd255) begin
                pr_tcol = pr_tcol + 8'd1;
            end
        end
        scan_clear_token();
    endfunction

    function automatic void stats_apply_config(logic [7:0] idx, logic [7:0] value);
        if (idx == REG_COLUMN_INDEX) begin
            pr_col = value;
        end else if (idx == REG_SKIP_FIRST_LINE) begin
            pr_skip = value[0];
            // the header flag follows the register only until the stream's first byte
            if (!pr_started) pr_header = pr_skip;
        end
    endfunction

    // Advance the predictor by one accepted beat; an end beat queues one result.
    function automatic void csv_stats_predict(in_beat_t b);
        logic [7:0] c;
        out_beat_t  r;
        bit         any;
        c = b.data_byte;
        if (b.end_of_input) begin
            if (!pr_header) scan_close_token();
            any           = pr_count != 0;
            r.value_min   = any ? pr_min[31:0] : '0;
            r.value_max   = any ? pr_max[31:0] : '0;
            r.value_sum   = pr_sum;
            r.value_count = pr_count;
            r.any_valid   = any;
            stats_exp_q.push_back(r);
            stats_clear_all();
            return;
        end
        pr_started = 1'b1;
        if (pr_header) begin
            if (c == CH_NEWLINE) pr_header = 1'b0;
            return;
        end
        if (c == CH_COMMA || c == CH_NEWLINE) begin
            scan_close_token();
            if (c == CH_NEWLINE) begin
                pr_tcol      = '0;
                pr_line_done = 1'b0;
            end
            return;
        end
        if (pr_line_done) return;
        if (!pr_in_tok) begin
            pr_in_tok = 1'b1;
            if (pr_tcol == pr_col) begin
                pr_last_quote = c == CH_QUOTE;
                if (c == CH_QUOTE) pr_open_quote = 1'b1;
                else scan_char(c);
            end
            return;
        end
        if (pr_tcol == pr_col) begin
            pr_last_quote = c == CH_QUOTE;
            scan_char(c);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, result-side backpressure, scoreboard and watchdog
    // ------------------------------------------------------------------
    always #5 aclk = ~aclk;

    // Stall the result channel with a chance of about 12 in a hundred, except in the no-idle stretch.
    always @(negedge aclk) begin
        m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);
    end

    // Compare each result beat against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (stats_exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: min=%0d max=%0d sum=%0d cnt=%0d any=%0b",
                             m_data.value_min, m_data.value_max, m_data.value_sum,
                             m_data.value_count, m_data.any_valid);
            end else begin
                stats_exp = stats_exp_q.pop_front();
                if (m_data.value_min !== stats_exp.value_min ||
                    m_data.value_max !== stats_exp.value_max ||
                    m_data.value_sum !== stats_exp.value_sum ||
                    m_data.value_count !== stats_exp.value_count ||
                    m_data.any_valid !== stats_exp.any_valid) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: exp min=%0d max=%0d sum=%0d cnt=%0d any=%0b",
                                 stats_exp.value_min, stats_exp.value_max,
                                 stats_exp.value_sum, stats_exp.value_count,
                                 stats_exp.any_valid);
                        $display("                 got min=%0d max=%0d sum=%0d cnt=%0d any=%0b",
                                 m_data.value_min, m_data.value_max, m_data.value_sum,
                                 m_data.value_count, m_data.any_valid);
                    end
                end
            end
        end
    end

    // Count cycles with no beat on any channel; a stuck block ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one byte beat; idle first at random, hold valid until the handshake.
    task automatic send_beat(input logic [7:0] c, input logic eoi);
        in_beat_t b;
        b.data_byte    = c;
        b.end_of_input = eoi;
        @(negedge aclk);
        if (!no_idle && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        csv_stats_predict(b);
        beats_sent++;
    endtask

    task automatic send_text();
        while (text_q.size() > 0) send_beat(text_q.pop_front(), 1'b0);
    endtask

    // Close the stream; the byte that rides with the end marker is ignored.
    task automatic send_end();
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // Hold off the sender until every result is in, then let the pipeline settle.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stats_exp_q.size() == 0) break;
        end
        repeat (RESULT_SETTLE) @(posedge aclk);
    endtask

    // Write one register; only called with the block idle.
    task automatic cfg_write(input logic [7:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        stats_apply_config(idx, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_VTAB;
            3:       return CH_FFEED;
            default: return CH_CRET;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    // Append a numeric token: optional quotes, leading space, sign, digits, trailing junk.
    task automatic push_number();
        int qmode;
        int pick;
        qmode = $urandom_range(9);
        pick  = $urandom_range(99);
        if (qmode <= 1) text_q.push_back(CH_QUOTE);
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) text_q.push_back(pick_space());
        case ($urandom_range(2))
            1:       text_q.push_back(CH_PLUS);
            2:       text_q.push_back(CH_MINUS);
            default: ;
        endcase
        if (pick < 8) begin
            case ($urandom_range(4))
                0:       push_str("2147483647");
                1:       push_str("2147483648");
                2:       push_str("2147483649");
                3:       push_str("99999999999");
                default: push_str("0");
            endcase
        end else if (pick < 15) begin
            repeat ($urandom_range(9, 12)) text_q.push_back(pick_digit());
        end else begin
            repeat ($urandom_range(1, 4)) text_q.push_back(pick_digit());
        end
        if ($urandom_range(9) == 0) text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
        if (qmode == 0 || qmode == 2) text_q.push_back(CH_QUOTE);
    endtask

    // Append one field: mostly numbers, with empty, junk, quote, sign-only and noise fields.
    task automatic push_field();
        int sel;
        sel = $urandom_range(99);
        if (sel < 65) begin
            push_number();
        end else if (sel < 75) begin
            // empty field: skipped, does not count as a column
        end else if (sel < 83) begin
            repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end else if (sel < 88) begin
            text_q.push_back(CH_QUOTE);
        end else if (sel < 93) begin
            text_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        end else if (sel < 97) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(pick_space());
        end else begin
            text_q.push_back(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // End marker on an empty stream: no value, all fields zero.
    task automatic test_empty_stream();
        send_end();
    endtask

    // Leading space, signs, saturation both ways, trailing junk, a bare sign.
    task automatic test_number_forms();
        push_str(" -2147483649,");
        text_q.push_back(CH_NEWLINE);
        text_q.push_back(CH_TAB);
        push_str("+2147483648x");
        text_q.push_back(CH_NEWLINE);
        push_str("-\n");
        text_q.push_back(8'h00);
        text_q.push_back(CH_NEWLINE);
        push_str("0");
        send_text();
        send_end();
    endtask

    // Lone quote, quote at one end only, quoted value, empty fields ahead of the column.
    task automatic test_quote_cases();
        drain_results();
        cfg_write(REG_COLUMN_INDEX, 8'd1);
        push_str("a,\"\n,,b,\"5\n1,\"-7\"\n9,8\"");
        send_text();
        send_end();
    endtask

    // Header row skipped, header left open at the end, skip written after the first byte.
    task automatic test_header_row();
        drain_results();
        cfg_write(REG_COLUMN_INDEX, 8'd0);
        cfg_write(REG_SKIP_FIRST_LINE, 8'd1);
        push_str("h,1\n4\n");
        send_text();
        send_end();
        push_str("h1");
        send_text();
        send_end();
        drain_results();
        cfg_write(REG_SKIP_FIRST_LINE, 8'd0);
        send_beat("3", 1'b0);
        drain_results();
        // stream already started: the header flag must not follow this write
        cfg_write(REG_SKIP_FIRST_LINE, 8'd1);
        push_str("\n5");
        send_text();
        send_end();
        push_str("5\n6");
        send_text();
        send_end();
        drain_results();
        cfg_write(REG_SKIP_FIRST_LINE, 8'd0);
    endtask

    // Column 255 on a line longer than that: the column counter saturates.
    task automatic test_long_line();
        drain_results();
        cfg_write(REG_COLUMN_INDEX, 8'd255);
        repeat (258) begin
            text_q.push_back(pick_digit());
            text_q.push_back(CH_COMMA);
        end
        text_q.push_back(CH_NEWLINE);
        push_str("1,2");
        send_text();
        send_end();
    endtask

    // Random CSV streams with random content, some noise, and config changes between them.
    task automatic test_random_streams();
        int start_beats;
        int nstreams;
        int sel;
        int nlines;
        int ntok;
        start_beats = beats_sent;
        nstreams    = 0;
        while (beats_sent - start_beats < RANDOM_BEATS || nstreams < 60) begin
            no_idle = nstreams >= 20 && nstreams < 32;
            if ($urandom_range(99) < 40) begin
                drain_results();
                sel = $urandom_range(99);
                if (sel < 70)      cfg_write(REG_COLUMN_INDEX, 8'($urandom_range(3)));
                else if (sel < 88) cfg_write(REG_COLUMN_INDEX, 8'($urandom_range(4, 40)));
                else               cfg_write(REG_COLUMN_INDEX, 8'($urandom_range(41, 255)));
                if ($urandom_range(1)) cfg_write(REG_SKIP_FIRST_LINE, 8'($urandom_range(1)));
            end
            if ($urandom_range(99) < 8) begin
                repeat ($urandom_range(5, 30)) text_q.push_back(8'($urandom_range(255)));
            end else if (pr_col >= 4 && pr_col <= 40) begin
                // wide lines of short fields so the selected column is reachable
                repeat ($urandom_range(1, 2)) begin
                    ntok = pr_col - 1 + $urandom_range(0, 4);
                    for (int t = 0; t < ntok; t++) begin
                        if (t > 0) text_q.push_back(CH_COMMA);
                        if ($urandom_range(4) == 0) text_q.push_back(CH_MINUS);
                        if ($urandom_range(9) != 0) text_q.push_back(pick_digit());
                    end
                    text_q.push_back(CH_NEWLINE);
                end
            end else begin
                nlines = $urandom_range(1, 5);
                for (int ln = 0; ln < nlines; ln++) begin
                    ntok = $urandom_range(1, (pr_col < 4) ? pr_col + 3 : 4);
                    for (int t = 0; t < ntok; t++) begin
                        if (t > 0) text_q.push_back(CH_COMMA);
                        push_field();
                    end
                    if ($urandom_range(9) == 0) text_q.push_back(CH_COMMA);
                    // the last line may stay open; the end marker closes its field
                    if (ln < nlines - 1 || $urandom_range(9) >= 3) text_q.push_back(CH_NEWLINE);
                end
            end
            send_text();
            send_end();
            nstreams++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pr_col    = '0;
        pr_skip   = 1'b0;
        stats_clear_all();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_stream();
        test_number_forms();
        test_quote_cases();
        test_header_row();
        test_long_line();
        test_random_streams();

        drain_results();
        repeat (2 * RESULT_SETTLE) @(posedge aclk);
        if (mismatches == 0 && stats_exp_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
